@@ rtl/core/bpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bpe_pkg;

   localparam int MAX_POINTS   = 16;
   localparam int TIME_BITS    = 32;
   localparam int LEVEL_BITS   = 16;
   localparam int IDX_BITS     = 4;
   localparam int CNT_BITS     = 5;
   localparam int FRAC_SHIFT   = 16;
   localparam int SLOPE_FRAC   = 32;
   localparam int SLOPE_BITS   = 48;
   localparam int MPLIER_BITS  = TIME_BITS + 1;
   localparam int PROD_BITS    = SLOPE_BITS + MPLIER_BITS;
   localparam int DVD_BITS     = LEVEL_BITS + SLOPE_FRAC;
   localparam int DSR_BITS     = TIME_BITS + 1;
   localparam int STEP_BITS    = 6;
   localparam int RES_BITS     = TIME_BITS + 3;

   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [1:0] KIND_FRAC = 2'd0;
   localparam logic [1:0] KIND_REL  = 2'd2;

   typedef struct packed {
      logic                  hold;
      logic [1:0]            kind;
      logic [LEVEL_BITS-1:0] level;
      logic [TIME_BITS-1:0]  time_v;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_ST_RD,
      S_W_CHK, S_W_MUL, S_W_WAIT, S_W_ABS, S_W_CMP,
      S_H_RD, S_H_CHK,
      S_P_BASE, S_P_WAIT, S_P_ABS, S_P_PREV,
      S_N_MUL, S_N_WAIT, S_N_ABS,
      S_M_DIV, S_L_DIV, S_D_WAIT, S_SLOPE,
      S_O_RD, S_O_CHK, S_O_WAIT, S_O_FIRE
   } state_type;

   typedef enum logic {RD_NEXT, RD_PREV} rd_sel_type;
   typedef enum logic [1:0] {PS_LAST, PS_PREV, PS_POS} prev_sel_type;
   typedef enum logic {DV_MID, DV_LAST} div_sel_type;
   typedef enum logic {MS_ABS, MS_OUT} mul_sel_type;

   typedef struct packed {
      logic         tbl_write;
      logic         init_start;
      logic         pos_load;
      logic         next_inc;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         mul_start;
      mul_sel_type  mul_sel;
      logic         abs_load;
      prev_sel_type prev_sel;
      logic         prev_load;
      logic         base_load;
      logic         div_start;
      div_sel_type  div_sel;
      logic         slope_load;
      logic         last_pos;
      logic         out_fire;
      logic         out_ramp;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
      logic next_lt;
      logic pos_ge_abs;
      logic ent_hold;
      logic slope_zero;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/breakpoint_envelope_generator.sv @@
// Piecewise-linear envelope. Write items load one breakpoint without raising busy; start and
// sample items hold busy until done. A start runs one serial multiply for the breakpoint time
// and one serial divide for the slope. A sample runs one serial multiply per breakpoint time
// checked, plus up to two serial multiplies and one serial divide per breakpoint passed, then
// forms the output (a serial multiply when the ramp is evaluated). The result strobe rsp_valid
// is high for one cycle and cannot be stalled; the receiver must take every beat.
`timescale 1ns / 1ps
`default_nettype none
module breakpoint_envelope_generator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_action,
   input  wire logic [bpe_pkg::IDX_BITS-1:0]   req_entry_index,
   input  wire logic [bpe_pkg::TIME_BITS-1:0]  req_entry_time,
   input  wire logic [bpe_pkg::LEVEL_BITS-1:0] req_entry_level,
   input  wire logic [1:0]                     req_entry_kind,
   input  wire logic                           req_entry_hold,
   input  wire logic [bpe_pkg::TIME_BITS-1:0]  req_sample_time,
   output logic                                rsp_valid,
   output logic [bpe_pkg::LEVEL_BITS-1:0]      rsp_envelope_level,
   output logic [bpe_pkg::CNT_BITS-1:0]        rsp_segment_index,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import bpe_pkg::*;

   localparam logic REG_COUNT    = 1'b0;
   localparam logic REG_DURATION = 1'b1;

   logic [CNT_BITS-1:0]  count_ff;
   logic [TIME_BITS-1:0] dur_ff;
   logic                 csr_wr;
   cmd_type              cmd;
   status_type           stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_BITS'(1);
         dur_ff   <= TIME_BITS'(48000);
      end else if (csr_wr) begin
         case (paddr[2])
            REG_COUNT:    count_ff <= pwdata[CNT_BITS-1:0];
            REG_DURATION: dur_ff   <= pwdata[TIME_BITS-1:0];
            default:      count_ff <= count_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_COUNT:    prdata = 32'(count_ff);
         REG_DURATION: prdata = 32'(dur_ff);
         default:      prdata = '0;
      endcase
   end

   bpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   bpe_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .point_count        (count_ff),
      .duration           (dur_ff),
      .req_entry_index    (req_entry_index),
      .req_entry_time     (req_entry_time),
      .req_entry_level    (req_entry_level),
      .req_entry_kind     (req_entry_kind),
      .req_entry_hold     (req_entry_hold),
      .req_sample_time    (req_sample_time),
      .rsp_valid          (rsp_valid),
      .rsp_envelope_level (rsp_envelope_level),
      .rsp_segment_index  (rsp_segment_index)
   );

endmodule
`default_nettype wire

@@ rtl/core/bpe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpe_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_action,
   input  wire bpe_pkg::status_type stat,
   output bpe_pkg::cmd_type        cmd,
   output logic                    busy
);
   import bpe_pkg::*;

   state_type state_ff, state_in;
   logic      seg_ff, seg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         seg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_START: begin
                     state_in = S_ST_RD;
                     seg_in   = 1'b0;
                  end
                  ACT_SAMPLE: begin
                     state_in = S_W_CHK;
                     seg_in   = 1'b1;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ST_RD:  state_in = S_N_MUL;
         S_W_CHK:  state_in = stat.next_lt ? S_W_MUL : S_O_RD;
         S_W_MUL:  state_in = S_W_WAIT;
         S_W_WAIT: if (!stat.mul_busy) state_in = S_W_ABS;
         S_W_ABS:  state_in = S_W_CMP;
         S_W_CMP:  state_in = stat.pos_ge_abs ? S_H_RD : S_O_RD;
         S_H_RD:   state_in = S_H_CHK;
         S_H_CHK:  state_in = (stat.next_lt && stat.ent_hold) ? S_W_CHK : S_P_BASE;
         S_P_BASE: state_in = S_P_WAIT;
         S_P_WAIT: if (!stat.mul_busy) state_in = S_P_ABS;
         S_P_ABS:  state_in = stat.next_lt ? S_P_PREV : S_L_DIV;
         S_P_PREV: state_in = S_N_MUL;
         S_N_MUL:  state_in = S_N_WAIT;
         S_N_WAIT: if (!stat.mul_busy) state_in = S_N_ABS;
         S_N_ABS:  state_in = S_M_DIV;
         S_M_DIV:  state_in = S_D_WAIT;
         S_L_DIV:  state_in = S_D_WAIT;
         S_D_WAIT: if (!stat.div_busy) state_in = S_SLOPE;
         S_SLOPE:  state_in = seg_ff ? S_W_CHK : S_IDLE;
         S_O_RD:   state_in = S_O_CHK;
         S_O_CHK: begin
            if ((stat.next_lt && stat.ent_hold) || stat.slope_zero) state_in = S_IDLE;
            else state_in = S_O_WAIT;
         end
         S_O_WAIT: if (!stat.mul_busy) state_in = S_O_FIRE;
         S_O_FIRE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_WRITE:  cmd.tbl_write  = 1'b1;
                  ACT_START:  cmd.init_start = 1'b1;
                  ACT_SAMPLE: cmd.pos_load   = 1'b1;
                  default:    cmd.tbl_write  = 1'b0;
               endcase
            end
         end
         S_ST_RD, S_W_CHK, S_H_RD, S_O_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
         end
         S_W_MUL, S_N_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_ABS;
         end
         S_W_ABS: begin
            cmd.abs_load = 1'b1;
            cmd.prev_sel = PS_LAST;
         end
         S_W_CMP: cmd.next_inc = stat.pos_ge_abs;
         S_H_CHK: begin
            if (stat.next_lt && stat.ent_hold) begin
               cmd.last_pos = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
            end
         end
         S_P_BASE: begin
            cmd.base_load = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_ABS;
         end
         S_P_ABS: begin
            cmd.abs_load = 1'b1;
            cmd.prev_sel = stat.next_lt ? PS_LAST : PS_POS;
         end
         S_P_PREV: begin
            cmd.prev_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_NEXT;
         end
         S_N_ABS: begin
            cmd.abs_load = 1'b1;
            cmd.prev_sel = PS_PREV;
         end
         S_M_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DV_MID;
         end
         S_L_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DV_LAST;
         end
         S_SLOPE: begin
            cmd.slope_load = 1'b1;
            cmd.last_pos   = seg_ff;
         end
         S_O_CHK: begin
            if ((stat.next_lt && stat.ent_hold) || stat.slope_zero) begin
               cmd.out_fire = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_OUT;
            end
         end
         S_O_FIRE: begin
            cmd.out_fire = 1'b1;
            cmd.out_ramp = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/bpe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bpe_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bpe_pkg::cmd_type                   cmd,
   output bpe_pkg::status_type                     stat,
   input  wire logic [bpe_pkg::CNT_BITS-1:0]       point_count,
   input  wire logic [bpe_pkg::TIME_BITS-1:0]      duration,
   input  wire logic [bpe_pkg::IDX_BITS-1:0]       req_entry_index,
   input  wire logic [bpe_pkg::TIME_BITS-1:0]      req_entry_time,
   input  wire logic [bpe_pkg::LEVEL_BITS-1:0]     req_entry_level,
   input  wire logic [1:0]                         req_entry_kind,
   input  wire logic                               req_entry_hold,
   input  wire logic [bpe_pkg::TIME_BITS-1:0]      req_sample_time,
   output logic                                    rsp_valid,
   output logic [bpe_pkg::LEVEL_BITS-1:0]          rsp_envelope_level,
   output logic [bpe_pkg::CNT_BITS-1:0]            rsp_segment_index
);
   import bpe_pkg::*;

   entry_type tbl_mem [MAX_POINTS];
   entry_type ent_ff;
   logic [IDX_BITS-1:0] rd_addr;

   logic [CNT_BITS-1:0]         next_ff, next_in, used_cnt;
   logic [TIME_BITS-1:0]        last_ff, last_in, pos_ff, pos_in;
   logic [TIME_BITS-1:0]        abs_ff, abs_in, prev_ff, prev_in;
   logic [LEVEL_BITS-1:0]       base_ff, base_in;
   logic signed [SLOPE_BITS-1:0] slope_ff, slope_in;

   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [SLOPE_BITS-1:0]  mcand_ff, mcand_in;
   logic [STEP_BITS-1:0]   mcnt_ff, mcnt_in;
   logic                   mrun_ff, mrun_in, oneg_ff, oneg_in;
   logic [SLOPE_BITS:0]    madd;

   logic [DVD_BITS-1:0]    dvd_ff, dvd_in;
   logic [DSR_BITS-1:0]    rem_ff, rem_in, dsr_ff, dsr_in;
   logic [STEP_BITS-1:0]   dcnt_ff, dcnt_in;
   logic                   drun_ff, drun_in, dneg_ff, dneg_in, dzero_ff, dzero_in;
   logic [DSR_BITS:0]      dshift, dtrial;

   logic                   rsp_valid_ff;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [CNT_BITS-1:0]    seg_ff;

   logic [TIME_BITS-1:0]   prev_v, frac_v, abs_v;
   logic [TIME_BITS:0]     rsum;
   logic signed [LEVEL_BITS:0] diff;
   logic signed [TIME_BITS:0]  range, rel;
   logic [LEVEL_BITS-1:0]  dmag;
   logic [TIME_BITS:0]     rmag, relmag;
   logic [SLOPE_BITS-1:0]  smag, qsat;
   logic [TIME_BITS:0]     qout;
   logic signed [RES_BITS-1:0] res;
   logic [LEVEL_BITS-1:0]  ramp_lvl;

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         tbl_mem[req_entry_index] <= '{hold: req_entry_hold, kind: req_entry_kind,
                                       level: req_entry_level, time_v: req_entry_time};
      end
   end

   assign rd_addr = (cmd.rd_sel == RD_PREV) ? IDX_BITS'(next_ff - 1'b1) : next_ff[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         ent_ff <= tbl_mem[rd_addr];
      end
   end

   always_comb begin
      if (point_count == '0) used_cnt = CNT_BITS'(1);
      else if (point_count > CNT_BITS'(MAX_POINTS)) used_cnt = CNT_BITS'(MAX_POINTS);
      else used_cnt = point_count;
   end

   always_comb begin
      case (cmd.prev_sel)
         PS_LAST: prev_v = last_ff;
         PS_PREV: prev_v = prev_ff;
         PS_POS:  prev_v = pos_ff;
         default: prev_v = last_ff;
      endcase
      frac_v = (|prod_ff[2*TIME_BITS-1:TIME_BITS+FRAC_SHIFT]) ? '1
               : prod_ff[TIME_BITS+FRAC_SHIFT-1:FRAC_SHIFT];
      rsum = {1'b0, prev_v} + {1'b0, ent_ff.time_v};
      case (ent_ff.kind)
         KIND_FRAC: abs_v = frac_v;
         KIND_REL:  abs_v = rsum[TIME_BITS] ? '1 : rsum[TIME_BITS-1:0];
         default:   abs_v = ent_ff.time_v;
      endcase
   end

   always_comb begin
      if (cmd.div_sel == DV_MID) begin
         diff  = $signed({1'b0, ent_ff.level}) - $signed({1'b0, base_ff});
         range = $signed({1'b0, abs_ff}) - $signed({1'b0, prev_ff});
      end else begin
         diff  = -$signed({1'b0, base_ff});
         range = $signed({1'b0, duration}) - $signed({1'b0, abs_ff});
      end
      dmag = diff[LEVEL_BITS] ? LEVEL_BITS'(-diff) : diff[LEVEL_BITS-1:0];
      rmag = range[TIME_BITS] ? (TIME_BITS+1)'(-range) : range;
      dshift = {rem_ff, dvd_ff[DVD_BITS-1]};
      dtrial = dshift - {1'b0, dsr_ff};
   end

   always_comb begin
      rel    = $signed({1'b0, pos_ff}) - $signed({1'b0, last_ff});
      relmag = rel[TIME_BITS] ? (TIME_BITS+1)'(-rel) : rel;
      smag   = slope_ff[SLOPE_BITS-1] ? SLOPE_BITS'(-slope_ff) : slope_ff;
      madd   = {1'b0, prod_ff[PROD_BITS-1:MPLIER_BITS]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      qout   = (|prod_ff[PROD_BITS-1:TIME_BITS+SLOPE_FRAC])
               ? {1'b1, {TIME_BITS{1'b0}}}
               : {1'b0, prod_ff[TIME_BITS+SLOPE_FRAC-1:SLOPE_FRAC]};
      if (oneg_ff) res = $signed(RES_BITS'(base_ff)) - $signed(RES_BITS'(qout));
      else res = $signed(RES_BITS'(base_ff)) + $signed(RES_BITS'(qout));
      if (res[RES_BITS-1]) ramp_lvl = '0;
      else if (|res[RES_BITS-2:LEVEL_BITS]) ramp_lvl = '1;
      else ramp_lvl = res[LEVEL_BITS-1:0];
   end

   always_comb begin
      if (dneg_ff) begin
         if (dvd_ff[DVD_BITS-1] && |dvd_ff[DVD_BITS-2:0]) qsat = {1'b1, {(SLOPE_BITS-1){1'b0}}};
         else qsat = SLOPE_BITS'(-dvd_ff);
      end else begin
         qsat = dvd_ff[DVD_BITS-1] ? {1'b0, {(SLOPE_BITS-1){1'b1}}} : SLOPE_BITS'(dvd_ff);
      end
   end

   always_comb begin
      next_in  = next_ff;
      last_in  = last_ff;
      pos_in   = pos_ff;
      abs_in   = abs_ff;
      prev_in  = prev_ff;
      base_in  = base_ff;
      slope_in = slope_ff;
      level_in = level_ff;
      if (cmd.init_start) begin
         next_in = '0;
         last_in = '0;
         base_in = '0;
         prev_in = '0;
      end
      if (cmd.pos_load) begin
         pos_in = req_sample_time;
         if (next_ff > used_cnt) next_in = used_cnt;
      end
      if (cmd.next_inc) next_in = next_ff + 1'b1;
      if (cmd.abs_load) abs_in = abs_v;
      if (cmd.prev_load) prev_in = abs_ff;
      if (cmd.base_load) base_in = ent_ff.level;
      if (cmd.slope_load) slope_in = dzero_ff ? '0 : $signed(qsat);
      if (cmd.last_pos) last_in = pos_ff;
      if (cmd.out_fire) begin
         if (cmd.out_ramp) level_in = ramp_lvl;
         else level_in = (next_ff < used_cnt) ? ent_ff.level : '0;
      end
   end

   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      mcnt_in  = mcnt_ff;
      mrun_in  = mrun_ff;
      oneg_in  = oneg_ff;
      if (cmd.mul_start) begin
         mrun_in = 1'b1;
         mcnt_in = STEP_BITS'(MPLIER_BITS);
         if (cmd.mul_sel == MS_ABS) begin
            mcand_in = SLOPE_BITS'(ent_ff.time_v);
            prod_in  = PROD_BITS'({1'b0, duration});
         end else begin
            mcand_in = smag;
            prod_in  = PROD_BITS'(relmag);
            oneg_in  = rel[TIME_BITS] ^ slope_ff[SLOPE_BITS-1];
         end
      end else if (mrun_ff) begin
         prod_in = {madd, prod_ff[MPLIER_BITS-1:1]};
         mcnt_in = mcnt_ff - 1'b1;
         mrun_in = (mcnt_ff != STEP_BITS'(1));
      end
   end

   always_comb begin
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      dcnt_in  = dcnt_ff;
      drun_in  = drun_ff;
      dneg_in  = dneg_ff;
      dzero_in = dzero_ff;
      if (cmd.div_start) begin
         drun_in  = 1'b1;
         dcnt_in  = STEP_BITS'(DVD_BITS);
         dvd_in   = {dmag, {SLOPE_FRAC{1'b0}}};
         rem_in   = '0;
         dsr_in   = rmag;
         dneg_in  = diff[LEVEL_BITS] ^ range[TIME_BITS];
         dzero_in = (range == '0);
      end else if (drun_ff) begin
         if (!dtrial[DSR_BITS]) begin
            rem_in = dtrial[DSR_BITS-1:0];
            dvd_in = {dvd_ff[DVD_BITS-2:0], 1'b1};
         end else begin
            rem_in = dshift[DSR_BITS-1:0];
            dvd_in = {dvd_ff[DVD_BITS-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 1'b1;
         drun_in = (dcnt_ff != STEP_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff      <= '0;
         last_ff      <= '0;
         base_ff      <= '0;
         slope_ff     <= '0;
         mrun_ff      <= 1'b0;
         drun_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_ff      <= next_in;
         last_ff      <= last_in;
         base_ff      <= base_in;
         slope_ff     <= slope_in;
         mrun_ff      <= mrun_in;
         drun_ff      <= drun_in;
         rsp_valid_ff <= cmd.out_fire;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      abs_ff   <= abs_in;
      prev_ff  <= prev_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      mcnt_ff  <= mcnt_in;
      oneg_ff  <= oneg_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      dcnt_ff  <= dcnt_in;
      dneg_ff  <= dneg_in;
      dzero_ff <= dzero_in;
      level_ff <= level_in;
      if (cmd.out_fire) seg_ff <= next_ff;
   end

   assign stat.mul_busy   = mrun_ff;
   assign stat.div_busy   = drun_ff;
   assign stat.next_lt    = (next_ff < used_cnt);
   assign stat.pos_ge_abs = (pos_ff >= abs_ff);
   assign stat.ent_hold   = ent_ff.hold;
   assign stat.slope_zero = (slope_ff == '0);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_envelope_level = level_ff;
   assign rsp_segment_index  = seg_ff;

endmodule
`default_nettype wire
